FILE: sv/b2u_pkg.sv
package b2u_pkg;

    localparam logic OP_DATA  = 1'b0;
    localparam logic OP_TABLE = 1'b1;

    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;

    localparam int TABLE_DEPTH = 128;
    localparam int TABLE_AW    = $clog2(TABLE_DEPTH);
    localparam logic [23:0] TWO_BYTE_MAX = 24'h00FFFF;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        MODE_KEEP = 2'd0,
        MODE_LF   = 2'd1,
        MODE_CR   = 2'd2,
        MODE_CRLF = 2'd3
    } mode_t;

    // One run of output bytes for one source byte; bytes[0] goes out first.
    typedef struct packed {
        logic [1:0]      count;
        logic [2:0][7:0] bytes;
    } run_t;

endpackage

FILE: sv/b2u_front.sv
module b2u_front
    import b2u_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [1:0]  line_break_mode,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        opcode,
    input  logic [7:0]  in_byte,
    input  logic [6:0]  entry_index,
    input  logic [23:0] entry_value,
    output logic        push_valid,
    input  logic        push_ready,
    output run_t        push_run
);

    logic [23:0] table_mem [TABLE_DEPTH];
    logic [23:0] rd_data_reg;

    mode_t       mode_reg;
    logic [7:0]  prev_byte_reg;
    logic [7:0]  prev_byte_next;
    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic        s1_lookup_reg;
    run_t        s1_run_reg;

    logic        in_fire;
    logic        s1_done;
    logic        is_lookup;
    run_t        imm_run;
    run_t        cur_run;

    assign in_fire = in_valid && in_ready;

    // Classify the incoming source byte against the previous one.
    always_comb
    begin
        imm_run   = '0;
        is_lookup = in_byte[7];
        if (in_byte == CH_LF || in_byte == CH_CR)
        begin
            if (in_byte == CH_LF && prev_byte_reg == CH_CR)
            begin
                // An LF right after a CR is swallowed unless breaks are kept.
                if (mode_reg == MODE_KEEP)
                begin
                    imm_run.count    = 2'd1;
                    imm_run.bytes[0] = in_byte;
                end
            end
            else
            begin
                case (mode_reg)
                    MODE_KEEP:
                    begin
                        imm_run.count    = 2'd1;
                        imm_run.bytes[0] = in_byte;
                    end
                    MODE_LF:
                    begin
                        imm_run.count    = 2'd1;
                        imm_run.bytes[0] = CH_LF;
                    end
                    MODE_CR:
                    begin
                        imm_run.count    = 2'd1;
                        imm_run.bytes[0] = CH_CR;
                    end
                    default:
                    begin
                        imm_run.count    = 2'd2;
                        imm_run.bytes[0] = CH_CR;
                        imm_run.bytes[1] = CH_LF;
                    end
                endcase
            end
        end
        else
        begin
            imm_run.count    = 2'd1;
            imm_run.bytes[0] = in_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && opcode == OP_TABLE)
        begin
            table_mem[entry_index] <= entry_value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && opcode == OP_DATA)
        begin
            rd_data_reg   <= table_mem[in_byte[TABLE_AW-1:0]];
            s1_lookup_reg <= is_lookup;
            s1_run_reg    <= imm_run;
        end
    end

    always_comb
    begin
        cur_run = s1_run_reg;
        if (s1_lookup_reg)
        begin
            cur_run.bytes[0] = rd_data_reg[23:16];
            cur_run.bytes[1] = rd_data_reg[15:8];
            cur_run.bytes[2] = rd_data_reg[7:0];
            if (rd_data_reg > TWO_BYTE_MAX)
            begin
                cur_run.count = 2'd3;
            end
            else
            begin
                cur_run.count    = 2'd2;
                cur_run.bytes[0] = rd_data_reg[15:8];
                cur_run.bytes[1] = rd_data_reg[7:0];
            end
        end
    end

    assign push_valid = s1_valid_reg && (cur_run.count != 2'd0);
    assign push_run   = cur_run;
    assign s1_done    = s1_valid_reg && ((cur_run.count == 2'd0) || push_ready);
    assign in_ready   = !s1_valid_reg || s1_done;

    always_comb
    begin
        s1_valid_next  = s1_valid_reg && !s1_done;
        prev_byte_next = prev_byte_reg;
        if (in_fire && opcode == OP_DATA)
        begin
            s1_valid_next  = 1'b1;
            prev_byte_next = in_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_KEEP;
            prev_byte_reg <= '0;
            s1_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                mode_reg <= mode_t'(line_break_mode);
            end
            prev_byte_reg <= prev_byte_next;
            s1_valid_reg  <= s1_valid_next;
        end
    end

endmodule

FILE: sv/b2u_queue.sv
module b2u_queue
    import b2u_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  run_t push_run,
    output logic pop_valid,
    input  logic pop_ready,
    output run_t pop_run
);

    run_t                entries [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW:0]   fill_reg;
    logic [QUEUE_AW:0]   fill_next;
    logic                do_push;
    logic                do_pop;

    assign push_ready = (fill_reg != QUEUE_AW'(0) + (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_run    = entries[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        fill_next = fill_reg;
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries[wr_ptr_reg] <= push_run;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            fill_reg <= fill_next;
        end
    end

endmodule

FILE: sv/b2u_back.sv
module b2u_back
    import b2u_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       pop_valid,
    output logic       pop_ready,
    input  run_t       pop_run,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       last_of_run
);

    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] out_byte_reg;
    logic       last_reg;
    logic [1:0] idx_reg;
    logic [1:0] idx_next;
    logic       load;
    logic       is_last;

    assign load      = pop_valid && (!out_valid_reg || out_ready);
    assign is_last   = (idx_reg == pop_run.count - 2'd1);
    assign pop_ready = load && is_last;

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (load)
        begin
            out_valid_next = 1'b1;
            idx_next       = is_last ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg <= pop_run.bytes[idx_reg];
            last_reg     <= is_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign last_of_run = last_reg;

endmodule

FILE: sv/byte_charset_to_utf8_converter_core.sv
// Channel  | Handshake            | Payload
// ---------+----------------------+-----------------------------------------------
// input    | in_valid / in_ready  | opcode, in_byte, entry_index, entry_value
// output   | out_valid / out_ready| out_byte, last_of_run
// config   | cfg_write_en         | line_break_mode
//
// One input beat per cycle is taken while in_ready is high; a table write does
// not enter the pipeline. Each source byte yields zero to three output beats,
// one per cycle while out_ready is high; the output register sets the rate.
// The first output beat of a byte passes the table read register, the queue
// and the output register.
// Reset clears the mode, the previous byte and all valids; table entries hold
// no value until written. A stalled output fills the two-run queue and then
// drops in_ready; the front keeps accepting while the queue has room.
module byte_charset_to_utf8_converter_core
    import b2u_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [1:0]  line_break_mode,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        opcode,
    input  logic [7:0]  in_byte,
    input  logic [6:0]  entry_index,
    input  logic [23:0] entry_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        last_of_run
);

    logic push_valid;
    logic push_ready;
    run_t push_run;
    logic pop_valid;
    logic pop_ready;
    run_t pop_run;

    b2u_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write_en    (cfg_write_en),
        .line_break_mode (line_break_mode),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .opcode          (opcode),
        .in_byte         (in_byte),
        .entry_index     (entry_index),
        .entry_value     (entry_value),
        .push_valid      (push_valid),
        .push_ready      (push_ready),
        .push_run        (push_run)
    );

    b2u_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_run   (push_run),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_run    (pop_run)
    );

    b2u_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .pop_valid   (pop_valid),
        .pop_ready   (pop_ready),
        .pop_run     (pop_run),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .last_of_run (last_of_run)
    );

endmodule

FILE: sv/b2u_checker.sv
module b2u_checker
    import b2u_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       opcode,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       last_of_run
);

    logic [1:0] run_len_reg;
    logic       data_seen_reg;

    // Counts output beats of the current run that were not flagged as last.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_len_reg   <= 2'd0;
            data_seen_reg <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                run_len_reg <= last_of_run ? 2'd0 : run_len_reg + 2'd1;
            end
            if (in_valid && in_ready && opcode == OP_DATA)
            begin
                data_seen_reg <= 1'b1;
            end
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last_of_run))
        else $error("output beat changed while stalled");

    a_run_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && run_len_reg == 2'd2 |-> last_of_run)
        else $error("run longer than three bytes");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> data_seen_reg)
        else $error("output beat without any data byte accepted");

    a_reset_quiet: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("output valid right after reset");

endmodule

bind byte_charset_to_utf8_converter_core b2u_checker u_b2u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .opcode      (opcode),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .last_of_run (last_of_run)
);
